@@ hw/rtl/masc_pkg.sv @@
package masc_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int PAT_REG_BYTES   = 16;
    localparam int HEAD_SPAN       = 5;
    localparam int CFG_AW          = 5;
    localparam int CFG_DW          = 64;
    localparam int COUNT_W         = 32;
    localparam int LEN_REG_W       = 5;

    // register indexes, byte address = 8 * index
    localparam logic [1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [1:0] REG_PAT_LEN  = 2'd2;
    localparam logic [1:0] REG_IGN_CASE = 2'd3;

    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_H        = 8'h68;
    localparam logic [7:0] CH_E        = 8'h65;
    localparam logic [7:0] CH_A        = 8'h61;
    localparam logic [7:0] CH_D        = 8'h64;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_Z     = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [2:0] PPF_SAT        = 3'd7;
    localparam logic [2:0] HEAD_CLOSE_MIN = 3'd6;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } cell_word_t;

    // one text position entering the decision tap
    typedef struct packed {
        logic       go;
        logic [7:0] data;
        logic       last;
        logic       head_open;
        logic       head_close;
        logic       hit;
    } decision_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        if (en && c >= CH_UP_A && c <= CH_UP_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/masc_cell.sv @@
module masc_cell
    import masc_pkg::*;
#(
    parameter int LW     = 5,
    parameter int OFFSET = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       move,
    input  logic       bubble,
    input  cell_word_t prev_word,
    input  logic [7:0] pat_byte,
    input  logic       ignore_case,
    input  logic [LW-1:0] len,
    input  logic       ok_in,
    input  logic       run_in,
    output cell_word_t cur_word,
    output cell_word_t nxt_word,
    output logic       ok_here,
    output logic       ok_out,
    output logic       run_out
);

    localparam logic [LW-1:0] OFF_V = LW'(OFFSET);

    cell_word_t word_reg;
    cell_word_t word_next;
    logic       in_use;
    logic       eq;

    always_comb begin
        if (bubble) begin
            word_next = '{data: 8'h00, valid: 1'b0, last: 1'b0};
        end else if (move) begin
            word_next = prev_word;
        end else begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
        end else begin
            word_reg <= word_next;
        end
    end

    assign eq      = fold_byte(word_next.data, ignore_case) == fold_byte(pat_byte, ignore_case);
    assign in_use  = OFF_V < len;
    // byte belongs to the text of the tap position
    assign ok_here = ok_in & word_next.valid;
    assign ok_out  = ok_here & ~word_next.last;
    assign run_out = run_in & (~in_use | (ok_here & eq));

    assign cur_word = word_reg;
    assign nxt_word = word_next;

endmodule

@@ hw/rtl/masc_ctrl.sv @@
module masc_ctrl
    import masc_pkg::*;
#(
    parameter int LW = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  decision_t          dec,
    input  logic [LW-1:0]      len,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [COUNT_W-1:0] m_tdata    // match_count [31:0]
);

    logic [LW-1:0]      skip_reg, skip_next;
    logic [2:0]         ppf_reg, ppf_next;
    logic               tag_reg, tag_next;
    logic               head_reg, head_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_data_reg, m_data_next;
    logic               load;

    always_comb begin
        skip_next    = skip_reg;
        ppf_next     = ppf_reg;
        tag_next     = tag_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        load         = dec.go & dec.last;

        if (dec.go) begin
            if (skip_reg != '0) begin
                skip_next = skip_reg - 1'b1;
            end else begin
                if (dec.data == CH_LT) begin
                    tag_next = 1'b1;
                    if (dec.head_open) begin
                        head_next = 1'b1;
                    end
                end
                if (dec.data == CH_GT) begin
                    tag_next = 1'b0;
                    // '/' of "/head" must not be the first text byte
                    if (ppf_reg >= HEAD_CLOSE_MIN && dec.head_close) begin
                        head_next = 1'b0;
                    end
                end
                if (dec.data != CH_LT && dec.data != CH_GT && !tag_reg && !head_reg &&
                    dec.hit) begin
                    if (count_reg != '1) begin
                        count_next = count_reg + 1'b1;
                    end
                    skip_next = len - 1'b1;
                end
            end
            if (ppf_reg != PPF_SAT) begin
                ppf_next = ppf_reg + 1'b1;
            end
        end

        if (load) begin
            m_data_next  = count_next;
            m_valid_next = 1'b1;
            skip_next    = '0;
            ppf_next     = '0;
            tag_next     = 1'b0;
            head_next    = 1'b0;
            count_next   = '0;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg    <= '0;
            ppf_reg     <= '0;
            tag_reg     <= 1'b0;
            head_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            skip_reg    <= skip_next;
            ppf_reg     <= ppf_next;
            tag_reg     <= tag_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_no_load_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        dec.go && dec.last |-> !(m_valid_reg && !m_tready))
        else $error("count loaded while output word still held");

    a_skip_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        dec.go && skip_reg != '0 && !dec.last |=> count_reg == $past(count_reg))
        else $error("count moved on a skipped position");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dec.go && dec.last) |=> count_reg >= $past(count_reg))
        else $error("running count fell inside a text");

    a_skip_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        !dec.go |=> skip_reg == $past(skip_reg))
        else $error("skip counter moved without a decision");
`endif

endmodule

@@ hw/rtl/markup_aware_substring_count_unit.sv @@
// Counts non-overlapping occurrences of the configured pattern (up to 16 bytes, optional
// ASCII case folding) in markup text, ignoring bytes inside tags and the head section.
// Text bytes stream in at one per cycle while s_tready is high, with no gaps required; a
// new text may follow the last byte of the previous one in the next cycle. Bytes shift
// through a row of LA+6 cells (LA = max(PATTERN_MAX-1, 5), 21 cells at the default) and
// each position is decided when it reaches the tap at cell LA, where cells 0..LA compare
// against the pattern in parallel. After the byte flagged by s_tlast reaches the tap the
// count is registered on the master side, the window being pushed along by later text
// or by empty slots. s_tready drops only while a final byte waits in the cell just ahead
// of the tap and the output register still holds an untaken word.
module markup_aware_substring_count_unit
    import masc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // text_byte [7:0]
    input  logic               s_tlast,    // last_byte
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [COUNT_W-1:0] m_tdata,    // match_count [31:0]
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [CFG_DW-1:0]  pwdata,
    output logic [CFG_DW-1:0]  prdata,
    output logic               pready
);

    localparam int LA    = (PATTERN_MAX - 1 > HEAD_SPAN) ? (PATTERN_MAX - 1) : HEAD_SPAN;
    localparam int DEPTH = LA + HEAD_SPAN + 1;
    localparam int LW    = $clog2(LA + 2);

    logic [CFG_DW-1:0]    pattern_low_reg;
    logic [CFG_DW-1:0]    pattern_high_reg;
    logic [LEN_REG_W-1:0] pattern_length_reg;
    logic                 ignore_case_reg;
    logic                 cfg_wr;

    logic [8*PAT_REG_BYTES-1:0] pat_all;
    logic [LW-1:0]              len_c;

    cell_word_t       in_word;
    cell_word_t       cur_w [DEPTH];
    cell_word_t       nxt_w [DEPTH];
    logic [DEPTH-1:0] ok_here;
    logic [DEPTH-1:0] ok_out;
    logic [DEPTH-1:0] run_out;
    logic [DEPTH-1:0] move_v;
    logic [DEPTH-1:0] bubble_v;
    logic [LA-1:0]    pend;
    logic [LA:0]      clear_above;
    logic             pending_any;
    logic             emit_pending;
    logic             stall;
    logic             accept;
    logic             drain;
    decision_t        dec;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            ignore_case_reg    <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_PAT_LOW:  pattern_low_reg    <= pwdata;
                REG_PAT_HIGH: pattern_high_reg   <= pwdata;
                REG_PAT_LEN:  pattern_length_reg <= pwdata[LEN_REG_W-1:0];
                REG_IGN_CASE: ignore_case_reg    <= pwdata[0];
                default:      pattern_low_reg    <= pattern_low_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_PAT_LOW:  prdata = pattern_low_reg;
            REG_PAT_HIGH: prdata = pattern_high_reg;
            REG_PAT_LEN:  prdata = {{(CFG_DW-LEN_REG_W){1'b0}}, pattern_length_reg};
            REG_IGN_CASE: prdata = {{(CFG_DW-1){1'b0}}, ignore_case_reg};
            default:      prdata = '0;
        endcase
    end

    assign pat_all = {pattern_high_reg, pattern_low_reg};
    assign len_c   = (int'(pattern_length_reg) > PATTERN_MAX) ? LW'(PATTERN_MAX)
                                                              : LW'(pattern_length_reg);

    // ---------------- shift control ----------------
    // A final byte not yet at the tap keeps the window moving: an empty slot is
    // inserted just below the oldest such byte so that later text stays contiguous.
    always_comb begin
        for (int j = 0; j < LA; j++) begin
            pend[j] = cur_w[j].valid & cur_w[j].last;
        end
        clear_above[LA] = 1'b1;
        for (int j = LA - 1; j >= 0; j--) begin
            clear_above[j] = clear_above[j+1] & ~pend[j];
        end
    end

    assign pending_any  = |pend;
    assign emit_pending = cur_w[LA-1].valid & cur_w[LA-1].last;
    assign stall        = m_tvalid & ~m_tready & emit_pending;
    assign s_tready     = ~stall;
    assign accept       = s_tvalid & s_tready;
    assign drain        = ~accept & pending_any & ~stall;

    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            if (j < LA) begin
                move_v[j]   = accept | (drain & clear_above[j]);
                bubble_v[j] = drain & pend[j] & clear_above[j+1];
            end else begin
                move_v[j]   = accept | drain;
                bubble_v[j] = 1'b0;
            end
        end
    end

    assign in_word = '{data: s_tdata, valid: 1'b1, last: s_tlast};

    // ---------------- row of cells ----------------
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        localparam int OFF = (j <= LA) ? (LA - j) : 0;

        cell_word_t prev_j;
        logic [7:0] pat_j;
        logic       ok_in_j;
        logic       run_in_j;

        if (j == 0) begin : g_first
            assign prev_j = in_word;
        end else begin : g_next
            assign prev_j = cur_w[j-1];
        end

        if (j < LA) begin : g_ahead
            assign ok_in_j  = ok_out[j+1];
            assign run_in_j = run_out[j+1];
        end else if (j == LA) begin : g_tap
            assign ok_in_j  = 1'b1;
            assign run_in_j = 1'b1;
        end else begin : g_behind
            assign ok_in_j  = 1'b0;
            assign run_in_j = 1'b0;
        end

        if (j <= LA && OFF < PAT_REG_BYTES) begin : g_pat
            assign pat_j = pat_all[8*OFF +: 8];
        end else begin : g_nopat
            assign pat_j = 8'h00;
        end

        masc_cell #(
            .LW     (LW),
            .OFFSET (OFF)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .move        (move_v[j]),
            .bubble      (bubble_v[j]),
            .prev_word   (prev_j),
            .pat_byte    (pat_j),
            .ignore_case (ignore_case_reg),
            .len         (len_c),
            .ok_in       (ok_in_j),
            .run_in      (run_in_j),
            .cur_word    (cur_w[j]),
            .nxt_word    (nxt_w[j]),
            .ok_here     (ok_here[j]),
            .ok_out      (ok_out[j]),
            .run_out     (run_out[j])
        );
    end

    // ---------------- decision tap ----------------
    assign dec.go        = (accept | drain) & nxt_w[LA].valid;
    assign dec.data      = nxt_w[LA].data;
    assign dec.last      = nxt_w[LA].last;
    assign dec.head_open = ok_here[LA-HEAD_SPAN] &
                           (nxt_w[LA-1].data == CH_H) & (nxt_w[LA-2].data == CH_E) &
                           (nxt_w[LA-3].data == CH_A) & (nxt_w[LA-4].data == CH_D) &
                           ((nxt_w[LA-5].data == CH_SPACE) | (nxt_w[LA-5].data == CH_GT));
    assign dec.head_close = (nxt_w[LA+5].data == CH_SLASH) & (nxt_w[LA+4].data == CH_H) &
                            (nxt_w[LA+3].data == CH_E) & (nxt_w[LA+2].data == CH_A) &
                            (nxt_w[LA+1].data == CH_D);
    assign dec.hit       = (len_c != '0) & run_out[0];

    masc_ctrl #(
        .LW (LW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dec      (dec),
        .len      (len_c),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ tb/markup_aware_substring_count_unit_tb.sv @@
`timescale 1ns / 100ps

module markup_aware_substring_count_unit_tb;
    import masc_pkg::*;

    localparam int LA    = (PATTERN_MAX_DEF - 1 > HEAD_SPAN) ? PATTERN_MAX_DEF - 1 : HEAD_SPAN;
    localparam int DEPTH = LA + 6;
    localparam int RANDOM_WORDS = 1400;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } text_word_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [COUNT_W-1:0] m_tdata;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CFG_AW-1:0]  paddr;
    logic [CFG_DW-1:0]  pwdata;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;

    markup_aware_substring_count_unit dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // register copy
    logic [63:0]        cfg_low;
    logic [63:0]        cfg_high;
    logic [4:0]         cfg_len;
    logic               cfg_icase;

    // text scanner state
    logic [7:0]         win [0:DEPTH-1];
    int                 win_fill;
    int                 past_five;
    bit                 in_tag;
    bit                 in_head;
    int                 skip_left;
    logic [COUNT_W-1:0] run_count;

    text_word_t         text_q [$];
    logic [COUNT_W-1:0] count_q [$];

    bit  calm;
    bit  in_taken;
    int  in_gap;
    int  out_gap;
    int  errors;
    int  words_sent;
    int  texts_sent;
    int  counts_seen;
    int  settings_used;
    longint hits_total;

    task automatic report_mismatch(string what, logic [COUNT_W-1:0] got,
                                   logic [COUNT_W-1:0] want);
        $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic logic [7:0] fold_char(logic [7:0] c);
        if (cfg_icase && c >= CH_UP_A && c <= CH_UP_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic logic [7:0] pattern_char(int k);
        if (k < 8) begin
            return cfg_low[8*k +: 8];
        end
        return cfg_high[8*(k-8) +: 8];
    endfunction

    function automatic void clear_scan();
        foreach (win[i]) win[i] = 8'h00;
        win_fill  = 0;
        past_five = 0;
        in_tag    = 0;
        in_head   = 0;
        skip_left = 0;
        run_count = '0;
    endfunction

    // settle the text position held at window index ip
    function automatic void decide_position(int ip);
        logic [7:0] c;
        int len;
        bit hit;
        c = win[ip];
        len = (cfg_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : cfg_len;
        if (skip_left > 0) begin
            skip_left--;
        end else begin
            if (c == CH_LT) begin
                if (ip >= 5 && win[ip-1] == CH_H && win[ip-2] == CH_E && win[ip-3] == CH_A &&
                    win[ip-4] == CH_D && (win[ip-5] == CH_SPACE || win[ip-5] == CH_GT)) begin
                    in_head = 1;
                end
                in_tag = 1;
            end
            if (c == CH_GT) begin
                if (past_five >= 6 && ip + 5 < DEPTH && win[ip+5] == CH_SLASH &&
                    win[ip+4] == CH_H && win[ip+3] == CH_E && win[ip+2] == CH_A &&
                    win[ip+1] == CH_D) begin
                    in_head = 0;
                end
                in_tag = 0;
            end
            if (c != CH_GT && !in_tag && !in_head && len > 0 && len - 1 <= ip) begin
                hit = 1;
                for (int k = 0; k < len; k++) begin
                    if (fold_char(win[ip-k]) != fold_char(pattern_char(k))) begin
                        hit = 0;
                    end
                end
                if (hit) begin
                    if (run_count != '1) begin
                        run_count++;
                    end
                    skip_left = len - 1;
                end
            end
        end
        if (past_five < 7) begin
            past_five++;
        end
    endfunction

    function automatic void count_step(logic [7:0] b, logic last);
        int start;
        for (int i = DEPTH - 1; i > 0; i--) begin
            win[i] = win[i-1];
        end
        win[0] = b;
        if (win_fill < DEPTH) begin
            win_fill++;
        end
        if (win_fill >= LA + 1) begin
            decide_position(LA);
        end
        if (last) begin
            start = (win_fill >= LA + 1) ? LA : win_fill;
            for (int ip = start; ip > 0; ip--) begin
                decide_position(ip - 1);
            end
            count_q.push_back(run_count);
            hits_total += run_count;
            clear_scan();
        end
    endfunction

    // sender
    always @(negedge aclk) begin
        bit nv;
        text_word_t w;
        nv = s_tvalid;
        if (!aresetn) begin
            nv = 1'b0;
        end else if (!s_tvalid || in_taken) begin
            nv = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (text_q.size() > 0) begin
                if (!calm && $urandom_range(0, 9) == 0) begin
                    in_gap = $urandom_range(0, 10);
                end else begin
                    w = text_q.pop_front();
                    s_tdata <= w.data;
                    s_tlast <= w.last;
                    nv = 1'b1;
                end
            end
        end
        s_tvalid <= nv;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (out_gap > 0) begin
            out_gap--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_gap = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        logic [COUNT_W-1:0] want;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                count_step(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                counts_seen++;
                if (count_q.size() == 0) begin
                    report_mismatch("count word with none pending", m_tdata, '0);
                end else begin
                    want = count_q.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch("match_count", m_tdata, want);
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        while (text_q.size() != 0 || count_q.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        repeat (LA + 8) @(posedge aclk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [63:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(idx) << 3;
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PAT_LOW: cfg_low = val;
            REG_PAT_HIGH: cfg_high = val;
            REG_PAT_LEN: cfg_len = val[4:0];
            REG_IGN_CASE: cfg_icase = val[0];
        endcase
    endtask

    function automatic void push_word(logic [7:0] b, logic last);
        text_word_t w;
        w.data = b;
        w.last = last;
        text_q.push_back(w);
        words_sent++;
        if (last) begin
            texts_sent++;
        end
    endfunction

    function automatic void add_str(ref logic [7:0] t[$], input string s);
        for (int i = 0; i < s.len(); i++) begin
            t.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] letter();
        string alpha;
        alpha = "abAB";
        return alpha[$urandom_range(0, 3)];
    endfunction

    function automatic logic [7:0] pattern_pick();
        string marks;
        marks = "<> /";
        case ($urandom_range(0, 9))
            0: return marks[$urandom_range(0, 3)];
            1: return 8'($urandom_range(0, 255));
            default: return letter();
        endcase
    endfunction

    function automatic logic [7:0] case_flip(logic [7:0] c);
        if ((c | CASE_OFFSET) >= CH_A && (c | CASE_OFFSET) <= 8'h7A &&
            $urandom_range(0, 2) == 0) begin
            return c ^ CASE_OFFSET;
        end
        return c;
    endfunction

    // mostly markup-like text built from fragments; some plain noise
    task automatic add_random_text(int max_len);
        logic [7:0] t[$];
        int goal;
        int len;
        int n;
        string marks;
        marks = "<>/ head";
        goal = $urandom_range(1, max_len);
        len = (cfg_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : cfg_len;
        if ($urandom_range(0, 6) == 0) begin
            while (t.size() < goal) begin
                if ($urandom_range(0, 1)) begin
                    t.push_back(8'($urandom_range(0, 255)));
                end else begin
                    t.push_back(marks[$urandom_range(0, 7)]);
                end
            end
        end else begin
            while (t.size() < goal) begin
                case ($urandom_range(0, 11))
                    0, 1, 2: begin
                        for (int k = 0; k < len; k++) t.push_back(case_flip(pattern_char(k)));
                    end
                    3: begin
                        n = $urandom_range(0, len);
                        for (int k = 0; k < n; k++) t.push_back(pattern_char(k));
                    end
                    4, 5: t.push_back(letter());
                    6: t.push_back(CH_SPACE);
                    7: begin
                        t.push_back(CH_LT);
                        n = $urandom_range(0, 4);
                        for (int k = 0; k < n; k++) t.push_back(letter());
                        t.push_back(CH_GT);
                    end
                    8: add_str(t, $urandom_range(0, 1) ? "<head>" : "<head ");
                    9: add_str(t, "</head>");
                    10: begin
                        case ($urandom_range(0, 3))
                            0: add_str(t, "<HEAD>");
                            1: add_str(t, "<Head ");
                            2: add_str(t, "<headx>");
                            default: add_str(t, "</HEAD>");
                        endcase
                    end
                    default: t.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
                endcase
            end
        end
        for (int i = 0; i < t.size(); i++) begin
            push_word(t[i], i == t.size() - 1);
        end
    endtask

    task automatic apply_setting(int p);
        logic [127:0] pat;
        logic [4:0]   len;
        logic         ic;
        pat = {$urandom, $urandom, $urandom, $urandom};
        ic  = 1'($urandom_range(0, 1));
        case (p)
            0: begin
                len = 5'd0;
                pat = '1;
                ic  = 1'b0;
            end
            1: len = 5'd1;
            2: len = 5'd16;
            3: len = 5'd31;
            4: begin
                len = 5'd1;
                pat = '1;
                ic  = 1'b0;
            end
            5: begin
                len = 5'd3;
                pat = '0;
            end
            default: begin
                len = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(1, 5));
            end
        endcase
        if (p > 5 || (p >= 1 && p <= 3)) begin
            for (int k = 0; k < 16 && k < len; k++) begin
                pat[8*k +: 8] = pattern_pick();
            end
        end
        wait_idle();
        reg_write(REG_PAT_LOW, pat[63:0]);
        reg_write(REG_PAT_HIGH, pat[127:64]);
        reg_write(REG_PAT_LEN, 64'(len));
        reg_write(REG_IGN_CASE, 64'(ic));
        settings_used++;
    endtask

    initial begin
        logic [7:0] t[$];
        int goal;
        int phase_start;
        int p;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_low   = '0;
        cfg_high  = '0;
        cfg_len   = '0;
        cfg_icase = 1'b1;
        clear_scan();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // settings straight out of reset: empty pattern, single-byte text
        push_word("z", 1'b1);
        settings_used = 1;
        wait_idle();
        reg_write(REG_PAT_LOW, 64'h6261);
        reg_write(REG_PAT_HIGH, '0);
        reg_write(REG_PAT_LEN, 64'd2);
        reg_write(REG_IGN_CASE, 64'd1);
        settings_used++;
        // head section hides a match, folded match after it, partial match at the end
        add_str(t, "<head>ab</head>aB");
        for (int i = 0; i < t.size(); i++) push_word(t[i], i == t.size() - 1);
        push_word("x", 1'b0);
        push_word("a", 1'b1);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b1);

        goal = words_sent + RANDOM_WORDS;
        p = 0;
        while (words_sent < goal) begin
            apply_setting(p);
            p++;
            phase_start = words_sent;
            while (words_sent - phase_start < 100 && words_sent < goal) begin
                if (words_sent > goal - 200) begin
                    calm = 1;
                end
                add_random_text(($urandom_range(0, 9) == 0) ? 90 : 30);
            end
        end

        wait_idle();
        $display("covered %0d text words in %0d texts under %0d register settings",
                 words_sent, texts_sent, settings_used);
        $display("%0d counts checked, %0d matches in total", counts_seen, hits_total);
        if (errors == 0) begin
            $display("markup_aware_substring_count_unit_tb: done, clean");
        end else begin
            $display("markup_aware_substring_count_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d counts outstanding", count_q.size());
        $display("markup_aware_substring_count_unit_tb: done, errors");
        $finish;
    end

endmodule
